FILE: sv/adampu_pkg.sv
package adampu_pkg;

  // Data formats
  localparam int DW   = 32;          // field width
  localparam int FB   = 24;          // fractional bits
  localparam int FW   = 24;          // width of the fraction registers
  localparam int DECW = 32;          // width of the decay register
  localparam int PW   = FB + 1;      // width of a beta power in 1.24

  localparam logic [FB:0]   ONE_FX  = (FB + 1)'(1) << FB;
  localparam logic [FB-1:0] HALF_FX = FB'(1) << (FB - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE,
    REG_DECAY,
    REG_EPSILON,
    REG_BETA_ONE,
    REG_BETA_TWO
  } cfg_reg_e;

  localparam logic [FW-1:0]   LR_RST    = FW'(16777);
  localparam logic [DECW-1:0] DECAY_RST = '0;
  localparam logic [FW-1:0]   EPS_RST   = FW'(2);
  localparam logic [FW-1:0]   B1_RST    = FW'(15099494);
  localparam logic [FW-1:0]   B2_RST    = FW'(16760439);

  typedef struct packed {
    logic [FW-1:0]   learning_rate;
    logic [DECW-1:0] decay;
    logic [FW-1:0]   epsilon;
    logic [FW-1:0]   beta_one;
    logic [FW-1:0]   beta_two;
  } cfg_t;

  typedef struct packed {
    logic signed [DW-1:0] gradient;
    logic signed [DW-1:0] weight;
    logic signed [DW-1:0] first_moment;
    logic [DW-1:0]        second_moment;
    logic                 last_of_step;
  } item_t;

  // Per-step factors that travel with an item
  typedef struct packed {
    logic [PW-1:0]   d1;       // 1 - beta_one^(t+1), never zero
    logic [PW-1:0]   d2;       // 1 - beta_two^(t+1), never zero
    logic [DW-1:0]   step;     // step counter t
  } step_ctx_t;

  typedef struct packed {
    logic signed [DW-1:0] new_weight;
    logic signed [DW-1:0] new_first_moment;
    logic [DW-1:0]        new_second_moment;
    logic                 step_done;
    logic                 saturated;
  } result_t;

endpackage

FILE: sv/adampu_if.sv
interface adampu_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [adampu_pkg::DW-1:0]    gradient;
  logic signed [adampu_pkg::DW-1:0]    weight;
  logic signed [adampu_pkg::DW-1:0]    first_moment;
  logic [adampu_pkg::DW-1:0]           second_moment;
  logic                                last_of_step;

  modport source (output valid, gradient, weight, first_moment, second_moment,
                  last_of_step, input ready);
  modport sink (input valid, gradient, weight, first_moment, second_moment,
                last_of_step, output ready);
endinterface

interface adampu_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [adampu_pkg::DW-1:0]    new_weight;
  logic signed [adampu_pkg::DW-1:0]    new_first_moment;
  logic [adampu_pkg::DW-1:0]           new_second_moment;
  logic                                step_done;
  logic                                saturated;

  modport source (output valid, new_weight, new_first_moment, new_second_moment,
                  step_done, saturated, input ready);
  modport sink (input valid, new_weight, new_first_moment, new_second_moment,
                step_done, saturated, output ready);
endinterface

FILE: sv/adampu_datapath.sv
module adampu_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  adampu_pkg::item_t     in_item_i,
  input  adampu_pkg::step_ctx_t in_ctx_i,
  input  adampu_pkg::cfg_t      cfg_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output adampu_pkg::result_t   out_res_o
);
  import adampu_pkg::*;

  localparam int QW   = DW + FB;      // dividend and quotient width
  localparam int RW   = FB + 1;       // bias divisor width
  localparam int DDW  = 2 * DW;       // decay denominator width
  localparam int G2W  = 2 * DW - FB;  // rounded gradient square width
  localparam int SQW  = QW + FB;      // radicand width
  localparam int RTW  = SQW / 2;      // root width
  localparam int SRW  = RTW + 2;      // root remainder width
  localparam int LOW  = QW / 2;       // low half of mh for the product
  localparam int PRW  = FW + QW;      // lr_t * mh width
  localparam int CAPB = 62;           // step size cap exponent
  localparam int DENW = RTW + 1;

  typedef struct packed {
    logic signed [DW-1:0] w;
    logic                 last;
    logic                 sat;
    logic                 neg;
    logic signed [DW-1:0] mn;
    logic [DW-1:0]        vn;
    logic [RW-1:0]        d1;
    logic [RW-1:0]        d2;
    logic [DDW-1:0]       dd;
    logic [QW-1:0]        x1;
    logic [QW-1:0]        x2;
    logic [QW-1:0]        x3;
    logic [RW-1:0]        r1;
    logic [RW-1:0]        r2;
    logic [DDW-1:0]       r3;
  } div_t;

  typedef struct packed {
    logic signed [DW-1:0] w;
    logic                 last;
    logic                 sat;
    logic                 neg;
    logic signed [DW-1:0] mn;
    logic [DW-1:0]        vn;
    logic [PRW-1:0]       prod;
    logic [SQW-1:0]       s;
    logic [RTW-1:0]       root;
    logic [SRW-1:0]       rem;
  } sq_t;

  typedef struct packed {
    logic signed [DW-1:0] w;
    logic                 last;
    logic                 sat;
    logic                 neg;
    logic signed [DW-1:0] mn;
    logic [DW-1:0]        vn;
    logic [DENW-1:0]      den;
    logic                 big;
    logic [CAPB-1:0]      x;
    logic [DENW-1:0]      r;
  } md_t;

  // One restoring step for each of the three divisions
  function automatic div_t div_step(div_t s);
    div_t          n;
    logic [RW:0]   t1;
    logic [RW:0]   t2;
    logic [DDW:0]  t3;
    n  = s;
    t1 = {s.r1, s.x1[QW-1]};
    t2 = {s.r2, s.x2[QW-1]};
    t3 = {s.r3, s.x3[QW-1]};
    if (t1 >= {1'b0, s.d1}) begin
      n.r1 = RW'(t1 - {1'b0, s.d1});
      n.x1 = {s.x1[QW-2:0], 1'b1};
    end else begin
      n.r1 = t1[RW-1:0];
      n.x1 = {s.x1[QW-2:0], 1'b0};
    end
    if (t2 >= {1'b0, s.d2}) begin
      n.r2 = RW'(t2 - {1'b0, s.d2});
      n.x2 = {s.x2[QW-2:0], 1'b1};
    end else begin
      n.r2 = t2[RW-1:0];
      n.x2 = {s.x2[QW-2:0], 1'b0};
    end
    if (t3 >= {1'b0, s.dd}) begin
      n.r3 = DDW'(t3 - {1'b0, s.dd});
      n.x3 = {s.x3[QW-2:0], 1'b1};
    end else begin
      n.r3 = t3[DDW-1:0];
      n.x3 = {s.x3[QW-2:0], 1'b0};
    end
    return n;
  endfunction

  // One bit pair of the square root
  function automatic sq_t sq_step(sq_t s);
    sq_t            n;
    logic [SRW+1:0] sh;
    logic [SRW+1:0] trial;
    n     = s;
    sh    = {s.rem, s.s[SQW-1:SQW-2]};
    trial = (SRW + 2)'({s.root, 2'b01});
    n.s   = {s.s[SQW-3:0], 2'b00};
    if (sh >= trial) begin
      n.rem  = SRW'(sh - trial);
      n.root = {s.root[RTW-2:0], 1'b1};
    end else begin
      n.rem  = sh[SRW-1:0];
      n.root = {s.root[RTW-2:0], 1'b0};
    end
    return n;
  endfunction

  // One restoring step of the step size division
  function automatic md_t md_step(md_t s);
    md_t           n;
    logic [DENW:0] t;
    n = s;
    t = {s.r, s.x[CAPB-1]};
    if (t >= {1'b0, s.den}) begin
      n.r = DENW'(t - {1'b0, s.den});
      n.x = {s.x[CAPB-2:0], 1'b1};
    end else begin
      n.r = t[DENW-1:0];
      n.x = {s.x[CAPB-2:0], 1'b0};
    end
    return n;
  endfunction

  logic en;
  assign en          = ~out_valid_o | out_ready_i;
  assign in_ready_o  = en;

  // Valid bits of all stages
  logic [2:0]    vf_q;
  logic [QW:0]   dv_q;
  logic          mv_q;
  logic [RTW:0]  sv_q;
  logic [CAPB:0] mdv_q;
  logic          out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q      <= '0;
      dv_q      <= '0;
      mv_q      <= 1'b0;
      sv_q      <= '0;
      mdv_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vf_q      <= {vf_q[1:0], in_valid_i};
      dv_q      <= {dv_q[QW-1:0], vf_q[2]};
      mv_q      <= dv_q[QW];
      sv_q      <= {sv_q[RTW-1:0], mv_q};
      mdv_q     <= {mdv_q[CAPB-1:0], sv_q[RTW]};
      out_vld_q <= mdv_q[CAPB];
    end
  end

  // Stage 1: moment and square products, decay product
  logic [DW-1:0]              gmag;
  logic [FB:0]                omb1;
  logic [FB:0]                omb2;
  logic signed [DW+FB:0]      pm1_q;
  logic signed [DW+FB+1:0]    pg1_q;
  logic [2*DW-1:0]            gsq_q;
  logic [2*DW-1:0]            dprod_q;
  logic signed [DW-1:0]       w1_q;
  logic [DW-1:0]              v1_q;
  logic                       last1_q;
  logic [RW-1:0]              d1_1_q;
  logic [RW-1:0]              d2_1_q;

  assign gmag = in_item_i.gradient[DW-1] ? (~in_item_i.gradient + 1'b1)
                                         : in_item_i.gradient;
  assign omb1 = ONE_FX - {1'b0, cfg_i.beta_one};
  assign omb2 = ONE_FX - {1'b0, cfg_i.beta_two};

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm1_q   <= $signed({1'b0, cfg_i.beta_one}) * in_item_i.first_moment;
      pg1_q   <= $signed({1'b0, omb1}) * in_item_i.gradient;
      gsq_q   <= gmag * gmag;
      dprod_q <= cfg_i.decay * in_ctx_i.step;
      w1_q    <= in_item_i.weight;
      v1_q    <= in_item_i.second_moment;
      last1_q <= in_item_i.last_of_step;
      d1_1_q  <= in_ctx_i.d1;
      d2_1_q  <= in_ctx_i.d2;
    end
  end

  // Stage 2: round first moment, gradient square and decay denominator
  logic signed [DW+FB+2:0] msum;
  logic signed [DW+FB+2:0] mr;
  logic                    m_ovf;
  logic [2*DW-1:0]         gsum;
  logic [2*DW:0]           ddsum;
  logic signed [DW-1:0]    mn2_q;
  logic                    satm2_q;
  logic [G2W-1:0]          g2_q;
  logic [DDW-1:0]          dd2_q;
  logic signed [DW-1:0]    w2_q;
  logic [DW-1:0]           v2_q;
  logic                    last2_q;
  logic [RW-1:0]           d1_2_q;
  logic [RW-1:0]           d2_2_q;

  assign msum  = pm1_q + pg1_q + $signed({1'b0, HALF_FX});
  assign mr    = msum >>> FB;
  assign m_ovf = ~(&mr[DW+FB+2:DW-1] | ~|mr[DW+FB+2:DW-1]);
  assign gsum  = gsq_q + (2 * DW)'(HALF_FX);
  assign ddsum = {1'b0, dprod_q} + (2 * DW + 1)'(ONE_FX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (m_ovf) begin
        mn2_q <= mr[DW+FB+2] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        mn2_q <= mr[DW-1:0];
      end
      satm2_q <= m_ovf;
      g2_q    <= gsum[2*DW-1:FB];
      dd2_q   <= ddsum[2*DW] ? {DDW{1'b1}} : ddsum[2*DW-1:0];
      w2_q    <= w1_q;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      d1_2_q  <= d1_1_q;
      d2_2_q  <= d2_1_q;
    end
  end

  // Stage 3: second moment products, first moment magnitude
  logic [FW+DW-1:0]      pv3_q;
  logic [FB+G2W:0]       pg3_q;
  logic [DW-1:0]         mmag3_q;
  logic                  neg3_q;
  logic signed [DW-1:0]  mn3_q;
  logic                  satm3_q;
  logic [DDW-1:0]        dd3_q;
  logic signed [DW-1:0]  w3_q;
  logic                  last3_q;
  logic [RW-1:0]         d1_3_q;
  logic [RW-1:0]         d2_3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pv3_q   <= cfg_i.beta_two * v2_q;
      pg3_q   <= omb2 * g2_q;
      mmag3_q <= mn2_q[DW-1] ? (~mn2_q + 1'b1) : mn2_q;
      neg3_q  <= mn2_q[DW-1];
      mn3_q   <= mn2_q;
      satm3_q <= satm2_q;
      dd3_q   <= dd2_q;
      w3_q    <= w2_q;
      last3_q <= last2_q;
      d1_3_q  <= d1_2_q;
      d2_3_q  <= d2_2_q;
    end
  end

  // Stage 4: round and clip second moment, load the dividers
  logic [FB+G2W+1:0] vsum;
  logic [G2W+1:0]    vr;
  logic              v_ovf;
  logic [DW-1:0]     vn4;
  div_t              dq [QW+1];

  assign vsum  = (FB + G2W + 2)'(pv3_q) + (FB + G2W + 2)'(pg3_q)
               + (FB + G2W + 2)'(HALF_FX);
  assign vr    = vsum[FB+G2W+1:FB];
  assign v_ovf = |vr[G2W+1:DW];
  assign vn4   = v_ovf ? {DW{1'b1}} : vr[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq[0].w    <= w3_q;
      dq[0].last <= last3_q;
      dq[0].sat  <= satm3_q | v_ovf;
      dq[0].neg  <= neg3_q;
      dq[0].mn   <= mn3_q;
      dq[0].vn   <= vn4;
      dq[0].d1   <= d1_3_q;
      dq[0].d2   <= d2_3_q;
      dq[0].dd   <= dd3_q;
      dq[0].x1   <= {mmag3_q, {FB{1'b0}}};
      dq[0].x2   <= {vn4, {FB{1'b0}}};
      dq[0].x3   <= QW'({cfg_i.learning_rate, {FB{1'b0}}});
      dq[0].r1   <= '0;
      dq[0].r2   <= '0;
      dq[0].r3   <= '0;
    end
  end

  // Divider stages: mh, vh and lr_t one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dq[k+1] <= div_step(dq[k]);
      end
    end
  end

  // Product lr_t * mh in two halves
  logic [FW-1:0]        lrt;
  logic [FW+LOW-1:0]    ph_q;
  logic [FW+LOW-1:0]    pl_q;
  logic [QW-1:0]        vh_q;
  logic signed [DW-1:0] wm_q;
  logic                 lastm_q;
  logic                 satm_q;
  logic                 negm_q;
  logic signed [DW-1:0] mnm_q;
  logic [DW-1:0]        vnm_q;

  assign lrt = dq[QW].x3[FW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q    <= lrt * dq[QW].x1[QW-1:LOW];
      pl_q    <= lrt * dq[QW].x1[LOW-1:0];
      vh_q    <= dq[QW].x2;
      wm_q    <= dq[QW].w;
      lastm_q <= dq[QW].last;
      satm_q  <= dq[QW].sat;
      negm_q  <= dq[QW].neg;
      mnm_q   <= dq[QW].mn;
      vnm_q   <= dq[QW].vn;
    end
  end

  // Sum the product and load the root stages
  sq_t sq [RTW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq[0].w    <= wm_q;
      sq[0].last <= lastm_q;
      sq[0].sat  <= satm_q;
      sq[0].neg  <= negm_q;
      sq[0].mn   <= mnm_q;
      sq[0].vn   <= vnm_q;
      sq[0].prod <= PRW'({ph_q, {LOW{1'b0}}}) + PRW'(pl_q);
      sq[0].s    <= {vh_q, {FB{1'b0}}};
      sq[0].root <= '0;
      sq[0].rem  <= '0;
    end
  end

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq[k+1] <= sq_step(sq[k]);
      end
    end
  end

  // Form the denominator, detect a capped step size
  logic [DENW-1:0] den_raw;
  logic [DENW-1:0] den;
  logic [DENW-1:0] prod_hi;
  logic            big;
  md_t             md [CAPB+1];

  assign den_raw = {1'b0, sq[RTW].root} + DENW'(cfg_i.epsilon);
  assign den     = (den_raw == '0) ? DENW'(1) : den_raw;
  assign prod_hi = DENW'(sq[RTW].prod[PRW-1:CAPB]);
  assign big     = prod_hi >= den;

  always_ff @(posedge clk_i) begin
    if (en) begin
      md[0].w    <= sq[RTW].w;
      md[0].last <= sq[RTW].last;
      md[0].sat  <= sq[RTW].sat;
      md[0].neg  <= sq[RTW].neg;
      md[0].mn   <= sq[RTW].mn;
      md[0].vn   <= sq[RTW].vn;
      md[0].den  <= den;
      md[0].big  <= big;
      md[0].x    <= sq[RTW].prod[CAPB-1:0];
      md[0].r    <= big ? '0 : prod_hi;
    end
  end

  for (genvar k = 0; k < CAPB; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en) begin
        md[k+1] <= md_step(md[k]);
      end
    end
  end

  // Apply the step to the weight and clip
  logic [DDW-1:0]        delta;
  logic signed [DDW-1:0] wext;
  logic signed [DDW-1:0] wsum;
  logic                  w_ovf;
  result_t               res_q;

  assign delta = md[CAPB].big ? (DDW'(1) << CAPB) : DDW'(md[CAPB].x);
  assign wext  = {{(DDW-DW){md[CAPB].w[DW-1]}}, md[CAPB].w};
  assign wsum  = md[CAPB].neg ? (wext + $signed(delta)) : (wext - $signed(delta));
  assign w_ovf = ~(&wsum[DDW-1:DW-1] | ~|wsum[DDW-1:DW-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (w_ovf) begin
        res_q.new_weight <= wsum[DDW-1] ? {1'b1, {(DW-1){1'b0}}}
                                        : {1'b0, {(DW-1){1'b1}}};
      end else begin
        res_q.new_weight <= wsum[DW-1:0];
      end
      res_q.new_first_moment  <= md[CAPB].mn;
      res_q.new_second_moment <= md[CAPB].vn;
      res_q.step_done         <= md[CAPB].last;
      res_q.saturated         <= md[CAPB].sat | w_ovf;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

endmodule

FILE: sv/adam_parameter_update.sv
// Adam parameter update, one parameter per transfer.
// Throughput: one item per cycle; an output stall freezes the whole pipeline.
// The depth comes from the bit-per-stage dividers (56), root (40) and step
//   size divider (62).
// Reset: async active low; clears valids, step counter, beta powers to 1.0 and
//   registers to their defaults.
module adam_parameter_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  adampu_item_if.sink                          items_i,
  adampu_result_if.source                      results_o,
  input  logic                                 cfg_we_i,
  input  logic [adampu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [adampu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import adampu_pkg::*;

  cfg_t          cfg_q;
  logic [DW-1:0] step_q;
  logic [PW-1:0] bpow1_q;
  logic [PW-1:0] bpow2_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate <= LR_RST;
      cfg_q.decay         <= DECAY_RST;
      cfg_q.epsilon       <= EPS_RST;
      cfg_q.beta_one      <= B1_RST;
      cfg_q.beta_two      <= B2_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LEARNING_RATE: cfg_q.learning_rate <= cfg_data_i[FW-1:0];
        REG_DECAY:         cfg_q.decay         <= cfg_data_i[DECW-1:0];
        REG_EPSILON:       cfg_q.epsilon       <= cfg_data_i[FW-1:0];
        REG_BETA_ONE:      cfg_q.beta_one      <= cfg_data_i[FW-1:0];
        REG_BETA_TWO:      cfg_q.beta_two      <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // Next beta powers, rounded to nearest
  logic [PW+FW:0] pr1;
  logic [PW+FW:0] pr2;
  logic [PW-1:0]  p1;
  logic [PW-1:0]  p2;
  logic [PW-1:0]  d1_raw;
  logic [PW-1:0]  d2_raw;
  step_ctx_t      ctx;

  assign pr1    = (PW + FW + 1)'(bpow1_q) * (PW + FW + 1)'(cfg_q.beta_one)
                + (PW + FW + 1)'(HALF_FX);
  assign pr2    = (PW + FW + 1)'(bpow2_q) * (PW + FW + 1)'(cfg_q.beta_two)
                + (PW + FW + 1)'(HALF_FX);
  assign p1     = pr1[FB+PW-1:FB];
  assign p2     = pr2[FB+PW-1:FB];
  assign d1_raw = ONE_FX - p1;
  assign d2_raw = ONE_FX - p2;
  assign ctx.d1   = (d1_raw == '0) ? PW'(1) : d1_raw;
  assign ctx.d2   = (d2_raw == '0) ? PW'(1) : d2_raw;
  assign ctx.step = step_q;

  // Advance step state after the last item of a step
  logic xfer_in;
  assign xfer_in = items_i.valid & items_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      bpow1_q <= ONE_FX;
      bpow2_q <= ONE_FX;
    end else if (xfer_in && items_i.last_of_step) begin
      step_q  <= step_q + 1'b1;
      bpow1_q <= p1;
      bpow2_q <= p2;
    end
  end

  item_t   item;
  result_t res;

  assign item.gradient      = items_i.gradient;
  assign item.weight        = items_i.weight;
  assign item.first_moment  = items_i.first_moment;
  assign item.second_moment = items_i.second_moment;
  assign item.last_of_step  = items_i.last_of_step;

  adampu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (items_i.valid),
    .in_ready_o  (items_i.ready),
    .in_item_i   (item),
    .in_ctx_i    (ctx),
    .cfg_i       (cfg_q),
    .out_valid_o (results_o.valid),
    .out_ready_i (results_o.ready),
    .out_res_o   (res)
  );

  assign results_o.new_weight        = res.new_weight;
  assign results_o.new_first_moment  = res.new_first_moment;
  assign results_o.new_second_moment = res.new_second_moment;
  assign results_o.step_done         = res.step_done;
  assign results_o.saturated         = res.saturated;

endmodule
